>>> rtl/etfi_pkg.sv
// Shared types and constants for the escape-time fractal iterator.
`timescale 1ns / 1ps

package etfi_pkg;

  // Fixed-point format of the plane coordinates and of z.
  localparam int Z_W       = 32;
  localparam int FRAC_BITS = 28;
  localparam int PROD_W    = 2 * Z_W;

  // Width of the updated component before it saturates back to Z_W bits.
  localparam int WIDE_RAW = PROD_W - FRAC_BITS + 2;
  localparam int WIDE_W   = (WIDE_RAW > Z_W + 2) ? WIDE_RAW : Z_W + 2;

  // |z|^2 >= 4 holds when any bit at or above this weight is set in the
  // exact sum of squares.
  localparam int ESC_BIT = 2 * FRAC_BITS + 2;

  // Iteration count and limit.
  localparam int COUNT_W        = 9;
  localparam int ITER_LIMIT_MAX = 256;

  // Number of iteration cells in the ring.
  localparam int CELL_COUNT = 4;

  // Stream payload widths.
  localparam int IN_TDATA_W  = 2 * Z_W;
  localparam int OUT_TDATA_W = 16;

  // Configuration port.
  localparam int CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    REG_FRACTAL_KIND   = 2'd0,
    REG_MAX_ITERATIONS = 2'd1,
    REG_JULIA_REAL     = 2'd2,
    REG_JULIA_IMAG     = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // One point in flight, handed from cell to cell around the ring.
  typedef struct packed {
    logic                    valid;
    logic                    done;
    logic                    escaped;
    logic [COUNT_W-1:0]      iter;
    logic signed [Z_W-1:0]   zr;
    logic signed [Z_W-1:0]   zi;
    logic signed [Z_W-1:0]   cr;
    logic signed [Z_W-1:0]   ci;
  } cell_data_t;

  // Clamp a widened component to the signed Z_W range.
  function automatic logic signed [Z_W-1:0] sat_z(input logic signed [WIDE_W-1:0] v);
    logic [WIDE_W-Z_W:0] top;
    logic signed [Z_W-1:0] res;
    top = v[WIDE_W-1:Z_W-1];
    if ((top == '0) || (top == '1)) begin
      res = v[Z_W-1:0];
    end else if (v[WIDE_W-1]) begin
      res = {1'b1, {(Z_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(Z_W-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

>>> rtl/etfi_cell.sv
// One iteration cell of the ring: squares z, then forms the next z or retires the point.
`timescale 1ns / 1ps

module etfi_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [etfi_pkg::COUNT_W-1:0] limit,
  input  etfi_pkg::cell_data_t        din,
  output etfi_pkg::cell_data_t        dout
);
  import etfi_pkg::*;

  cell_data_t               a_data;
  logic signed [PROD_W-1:0] prr;
  logic signed [PROD_W-1:0] pii;
  logic signed [PROD_W-1:0] pri;

  logic [PROD_W-1:0]        mag_sum;
  logic                     outside;
  logic                     stop;
  logic signed [PROD_W-1:0] diff;
  logic signed [WIDE_W-1:0] re_w;
  logic signed [WIDE_W-1:0] im_w;
  cell_data_t               dout_next;

  // Product stage: the three exact products of the current z.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_data <= '0;
    end else begin
      a_data <= din;
    end
    prr    <= $signed(din.zr) * $signed(din.zr);
    pii    <= $signed(din.zi) * $signed(din.zi);
    pri    <= $signed(din.zr) * $signed(din.zi);
  end

  // Escape and limit test on the squares, and the new components, floored before saturation.
  always_comb begin
    mag_sum = $unsigned(prr) + $unsigned(pii);
    outside = |mag_sum[PROD_W-1:ESC_BIT];
    stop    = outside || (a_data.iter >= limit);
    diff    = prr - pii;
    re_w    = $signed(WIDE_W'(diff >>> FRAC_BITS)) + $signed(WIDE_W'($signed(a_data.cr)));
    im_w    = $signed(WIDE_W'(pri >>> (FRAC_BITS - 1))) + $signed(WIDE_W'($signed(a_data.ci)));
  end

  // A live point either takes one step or retires with its escape flag;
  // a retired point passes through unchanged.
  always_comb begin
    dout_next = a_data;
    if (a_data.valid && !a_data.done) begin
      if (stop) begin
        dout_next.done    = 1'b1;
        dout_next.escaped = outside;
      end else begin
        dout_next.zr   = sat_z(re_w);
        dout_next.zi   = sat_z(im_w);
        dout_next.iter = COUNT_W'(a_data.iter + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout <= '0;
    end else begin
      dout <= dout_next;
    end
  end

endmodule

>>> rtl/escape_time_fractal_iterator_top.sv
// Top level of the escape-time fractal iterator: configuration, ring of cells, control.
//
//  Channel | Direction | Transfer condition        | Payload
//  s_*     | in        | s_tvalid && s_tready      | tdata[31:0] point_real, [63:32] point_imag
//  m_*     | out       | m_tvalid && m_tready      | tdata[8:0] iteration_count, [9] escaped
//  cfg_*   | in        | cfg_we                    | cfg_index selects, cfg_data value
//
// One point is in the ring at a time. Each iteration passes through the product
// register, then the update register of one cell. A point that retires in an earlier
// cell passes unchanged through the rest of the ring to the last cell, from which it
// moves to the output register; the next point can be taken in the cycle after that.
// Reset (synchronous) restores the register defaults and empties the ring.
// While the output register holds a result not yet taken, a finished point keeps
// circling the ring until the output register frees up; s_tready is high whenever
// the ring is empty, even with a result waiting at the output.
`timescale 1ns / 1ps

module escape_time_fractal_iterator_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [etfi_pkg::IN_TDATA_W-1:0]  s_tdata,   // [31:0] point_real, [63:32] point_imag
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [etfi_pkg::OUT_TDATA_W-1:0] m_tdata,   // [8:0] iteration_count, [9] escaped
  input  logic                             cfg_we,
  input  etfi_pkg::cfg_reg_t               cfg_index,
  input  logic [etfi_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import etfi_pkg::*;

  logic                  fractal_kind;
  logic [COUNT_W-1:0]    max_iterations;
  logic signed [Z_W-1:0] julia_real;
  logic signed [Z_W-1:0] julia_imag;
  logic [COUNT_W-1:0]    limit;

  state_t                state;
  state_t                state_next;
  logic                  s_accept;
  logic                  deliver;

  cell_data_t            link [CELL_COUNT+1];
  cell_data_t            tail;
  logic [CELL_COUNT-1:0] ring_valid;

  logic signed [Z_W-1:0] point_real;
  logic signed [Z_W-1:0] point_imag;

  logic [COUNT_W-1:0]    m_count;
  logic                  m_escaped;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      fractal_kind   <= 1'b0;
      max_iterations <= COUNT_W'(ITER_LIMIT_MAX);
      julia_real     <= '0;
      julia_imag     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRACTAL_KIND:   fractal_kind   <= cfg_data[0];
        REG_MAX_ITERATIONS: max_iterations <= cfg_data[COUNT_W-1:0];
        REG_JULIA_REAL:     julia_real     <= cfg_data[Z_W-1:0];
        REG_JULIA_IMAG:     julia_imag     <= cfg_data[Z_W-1:0];
      endcase
    end
  end

  // Limits above the supported maximum act as the maximum.
  assign limit = (max_iterations > COUNT_W'(ITER_LIMIT_MAX)) ? COUNT_W'(ITER_LIMIT_MAX)
                                                             : max_iterations;

  assign point_real = s_tdata[Z_W-1:0];
  assign point_imag = s_tdata[2*Z_W-1:Z_W];
  assign tail       = link[CELL_COUNT];

  // Control state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (s_accept) state_next = ST_RUN;
      ST_RUN:  if (deliver)  state_next = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    s_tready = (state == ST_IDLE);
    s_accept = s_tvalid && s_tready;
    deliver  = (state == ST_RUN) && tail.valid && tail.done && (!m_tvalid || m_tready);
  end

  // Ring head: a new point enters, otherwise the tail feeds back until its
  // result moves to the output register.
  always_comb begin
    link[0]       = tail;
    link[0].valid = tail.valid && !deliver;
    if (s_accept) begin
      link[0].valid   = 1'b1;
      link[0].done    = 1'b0;
      link[0].escaped = 1'b0;
      link[0].iter    = '0;
      if (fractal_kind) begin
        link[0].zr = point_real;
        link[0].zi = point_imag;
        link[0].cr = julia_real;
        link[0].ci = julia_imag;
      end else begin
        link[0].zr = '0;
        link[0].zi = '0;
        link[0].cr = point_real;
        link[0].ci = point_imag;
      end
    end
  end

  // Ring of iteration cells.
  for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
    etfi_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .limit (limit),
      .din   (link[i]),
      .dout  (link[i+1])
    );
    assign ring_valid[i] = link[i+1].valid;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (deliver) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (deliver) begin
      m_count   <= tail.iter;
      m_escaped <= tail.escaped;
    end
  end

  assign m_tdata = {{(OUT_TDATA_W-COUNT_W-1){1'b0}}, m_escaped, m_count};

  // At most one point is ever in the ring.
  a_single_token: assert property (@(posedge clk) disable iff (rst)
    $countones(ring_valid) <= 1)
    else $error("more than one point in the ring");

  // An idle controller leaves no point behind in the ring.
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (ring_valid == '0))
    else $error("ring not empty while idle");

  // A point that leaves the ring tail reaches the output register in the next cycle.
  a_deliver_out: assert property (@(posedge clk) disable iff (rst)
    deliver |=> m_tvalid)
    else $error("result not presented after retiring");

  // The count never exceeds the limit, and a point that did not escape ran to it.
  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_count <= limit))
    else $error("iteration count above limit");

  a_stay_full: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_escaped) |-> (m_count == limit))
    else $error("bounded point stopped before limit");

endmodule
